FILE: rtl/cce_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and word types of the console cursor engine.
package cce_pkg;

	localparam int TEXT_COLUMNS = 80;
	localparam int TEXT_ROWS    = 25;
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;

	localparam int COL_W      = $clog2(TEXT_COLUMNS);
	localparam int ROW_W      = $clog2(TEXT_ROWS);
	localparam int POS_W      = 12;
	localparam int DIM_W      = 13;
	localparam int DIM_MAX    = 4096;
	localparam int CALC_W     = 14;
	localparam int ADDR_W     = 11;
	localparam int WORD_W     = 16;
	localparam int GLYPH_W    = 7;
	localparam int ATTR_W     = 8;
	localparam int CHAR_W     = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [2:0] {
		ACT_GLYPH   = 3'd0,
		ACT_ERASE   = 3'd1,
		ACT_CELL    = 3'd2,
		ACT_CLEAR   = 3'd3,
		ACT_PRESENT = 3'd4
	} action_t;

	localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NOFB  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTR   = 2'd3;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] GLYPH_FIRST  = 8'd32;
	localparam logic [CHAR_W-1:0] GLYPH_LAST   = 8'd127;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [ATTR_W-1:0] attr;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [CHAR_W-1:0] char_code;
		logic              end_of_string;
	} item_t;

	typedef struct packed {
		action_t             action;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [GLYPH_W-1:0]  glyph_index;
		logic [ADDR_W-1:0]   cell_address;
		logic [WORD_W-1:0]   cell_word;
	} result_t;

	// up to two results per input word, count says how many are live
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} pair_t;

endpackage

FILE: rtl/cce_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for console characters and drawing commands.
interface cce_in_if import cce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_string;

	modport source (output valid, cmd, char_code, end_of_string, input ready);
	modport sink   (input valid, cmd, char_code, end_of_string, output ready);
endinterface

interface cce_out_if import cce_pkg::*; ();
	logic               valid;
	logic               ready;
	action_t            action;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [GLYPH_W-1:0] glyph_index;
	logic [ADDR_W-1:0]  cell_address;
	logic [WORD_W-1:0]  cell_word;
	logic               last;

	modport source (output valid, action, pos_x, pos_y, glyph_index, cell_address, cell_word,
		last, input ready);
	modport sink   (input valid, action, pos_x, pos_y, glyph_index, cell_address, cell_word,
		last, output ready);
endinterface

FILE: rtl/cce_cursor.sv
`timescale 1ns / 1ps
// Cursor state and the single-pass logic that turns one word into its results.
module cce_cursor import cce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output pair_t pair
);

	localparam logic signed [CALC_W-1:0] GW_S = CALC_W'(GLYPH_WIDTH);
	localparam logic signed [CALC_W-1:0] GH_S = CALC_W'(GLYPH_HEIGHT);
	localparam int AW = ROW_W + COL_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] px_q;
	logic [POS_W-1:0] py_q;

	// text grid
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic [COL_W:0]   t_col;
	logic [ROW_W:0]   t_row;
	logic [AW-1:0]    addr_full;
	result_t          t_res;

	// pixel console
	logic [DIM_W-1:0]         w_clip;
	logic [DIM_W-1:0]         h_clip;
	logic signed [CALC_W-1:0] w_lim;
	logic signed [CALC_W-1:0] h_lim;
	logic signed [CALC_W-1:0] x0, y0, x1, y1, x2, y2;
	logic                     p_emit;
	result_t                  p_res;
	result_t                  present_res;
	result_t                  clear_res;

	logic is_pixel;
	logic is_nofb;

	function automatic logic w_clip_over(input logic [DIM_W-1:0] d);
		return d > DIM_W'(DIM_MAX);
	endfunction

	assign is_pixel = (cfg.mode == MODE_PIXEL);
	assign is_nofb  = (cfg.mode == MODE_NOFB);

	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign addr_full = AW'(row_q) * AW'(TEXT_COLUMNS) + AW'(col_q);

	always_comb begin
		t_col = col_inc;
		t_row = {1'b0, row_q};
		if (item.char_code == CH_NEWLINE) begin
			t_col = '0;
			t_row = row_inc;
		end
		if (t_col >= (COL_W+1)'(TEXT_COLUMNS)) begin
			t_col = '0;
			t_row = row_inc;
		end
		if (t_row >= (ROW_W+1)'(TEXT_ROWS))
			t_row = '0;
	end

	always_comb begin
		t_res              = '0;
		t_res.action       = ACT_CELL;
		t_res.cell_address = ADDR_W'(addr_full);
		t_res.cell_word    = {cfg.attr, item.char_code};
	end

	assign w_clip = (w_clip_over(cfg.width))  ? DIM_W'(DIM_MAX) : cfg.width;
	assign h_clip = (w_clip_over(cfg.height)) ? DIM_W'(DIM_MAX) : cfg.height;
	assign w_lim  = $signed({1'b0, w_clip}) - GW_S;
	assign h_lim  = $signed({1'b0, h_clip}) - GH_S;

	always_comb begin
		x0     = $signed({2'b00, px_q});
		y0     = $signed({2'b00, py_q});
		x1     = x0;
		y1     = y0;
		p_emit = 1'b0;
		p_res  = '0;
		if (item.char_code == CH_NEWLINE) begin
			x1 = '0;
			y1 = y0 + GH_S;
		end else if (item.char_code == CH_BACKSPACE) begin
			if (x0 >= GW_S) begin
				x1           = x0 - GW_S;
				p_emit       = 1'b1;
				p_res.action = ACT_ERASE;
				p_res.pos_x  = POS_W'(x1);
				p_res.pos_y  = POS_W'(y0);
			end
		end else if (item.char_code >= GLYPH_FIRST && item.char_code <= GLYPH_LAST) begin
			p_emit            = 1'b1;
			p_res.action      = ACT_GLYPH;
			p_res.pos_x       = POS_W'(x0);
			p_res.pos_y       = POS_W'(y0);
			p_res.glyph_index = GLYPH_W'(item.char_code - GLYPH_FIRST);
			x1                = x0 + GW_S;
		end
		// wrap to the next line, then back to the top
		x2 = x1;
		y2 = y1;
		if (x1 >= w_lim) begin
			x2 = '0;
			y2 = y1 + GH_S;
		end
		if (y2 >= h_lim)
			y2 = '0;
	end

	always_comb begin
		present_res        = '0;
		present_res.action = ACT_PRESENT;
		clear_res          = '0;
		clear_res.action   = ACT_CLEAR;
		if (!is_pixel)
			clear_res.cell_word = {cfg.attr, CH_SPACE};
	end

	always_comb begin
		pair    = '0;
		pair.r1 = present_res;
		if (item.cmd) begin
			pair.r0    = clear_res;
			pair.count = is_pixel ? 2'd2 : 2'd1;
		end else if (is_pixel) begin
			if (p_emit) begin
				pair.r0    = p_res;
				pair.count = item.end_of_string ? 2'd2 : 2'd1;
			end else begin
				pair.r0    = present_res;
				pair.count = item.end_of_string ? 2'd1 : 2'd0;
			end
		end else if (!is_nofb) begin
			pair.r0    = t_res;
			pair.count = (item.char_code == CH_NEWLINE) ? 2'd0 : 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			px_q  <= '0;
			py_q  <= '0;
		end else if (step) begin
			if (item.cmd) begin
				if (is_pixel) begin
					px_q <= '0;
					py_q <= '0;
				end else begin
					col_q <= '0;
					row_q <= '0;
				end
			end else if (is_pixel) begin
				px_q <= POS_W'(x2);
				py_q <= POS_W'(y2);
			end else if (!is_nofb) begin
				col_q <= COL_W'(t_col);
				row_q <= ROW_W'(t_row);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(TEXT_COLUMNS) && row_q < ROW_W'(TEXT_ROWS))
		else $error("text cursor off the grid");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && item.cmd |=> (px_q == '0 && py_q == '0) || (col_q == '0 && row_q == '0))
		else $error("clear did not home a cursor");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && is_nofb && !item.cmd |=> $stable(px_q) && $stable(py_q)
			&& $stable(col_q) && $stable(row_q))
		else $error("cursor moved without a framebuffer");

endmodule

FILE: rtl/cce_out_stage.sv
`timescale 1ns / 1ps
// Result register: holds one or two results and hands them out a word at a time.
module cce_out_stage import cce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  pair_t        pair,
	output logic         free,
	cce_out_if.source    out
);

	logic    valid_q;
	logic    idx_q;
	pair_t   pair_q;
	result_t cur;
	logic    last_now;

	assign cur      = idx_q ? pair_q.r1 : pair_q.r0;
	assign last_now = idx_q || (pair_q.count == 2'd1);
	assign free     = !valid_q || (out.ready && last_now);

	assign out.valid        = valid_q;
	assign out.action       = cur.action;
	assign out.pos_x        = cur.pos_x;
	assign out.pos_y        = cur.pos_y;
	assign out.glyph_index  = cur.glyph_index;
	assign out.cell_address = cur.cell_address;
	assign out.cell_word    = cur.cell_word;
	assign out.last         = last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (valid_q && out.ready) begin
			if (last_now)
				valid_q <= 1'b0;
			else
				idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			pair_q <= pair;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free && pair.count != 2'd0)
		else $error("result register overwritten or loaded empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> pair_q.count != 2'd0 && (!idx_q || pair_q.count == 2'd2))
		else $error("result slot beyond count");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out.ready && !last_now && !load |=> valid_q && idx_q)
		else $error("second result of a pair dropped");

endmodule

FILE: rtl/console_cursor_engine.sv
`timescale 1ns / 1ps
// Top level: input register, configuration registers, cursor logic, result register.
// A word passes the input register, and its results are offered by the result register.
// One word per cycle while the result register is free; a pair holds it until both are taken.
// Words with no result (text newline, characters without a framebuffer) skip the result register.
// Reset: cursors go home, registers take their defaults (text mode, 1024 x 768, attribute 7).
module console_cursor_engine import cce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cce_in_if.sink                chars,
	cce_out_if.source             draws
);

	cfg_t  cfg_q;
	logic  valid_s1;
	item_t item_s1;
	pair_t pair;
	logic  free;
	logic  adv;
	logic  load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= '0;
			cfg_q.width  <= DIM_W'(1024);
			cfg_q.height <= DIM_W'(768);
			cfg_q.attr   <= ATTR_W'(7);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[MODE_W-1:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[DIM_W-1:0];
				REG_ATTR:   cfg_q.attr   <= cfg_data[ATTR_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// a word leaves the input register once its results fit in the result register
	assign adv         = valid_s1 && (pair.count == 2'd0 || free);
	assign load        = adv && pair.count != 2'd0;
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (chars.ready)
			valid_s1 <= chars.valid;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.cmd           <= chars.cmd;
			item_s1.char_code     <= chars.char_code;
			item_s1.end_of_string <= chars.end_of_string;
		end
	end

	cce_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.pair   (pair)
	);

	cce_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.pair   (pair),
		.free   (free),
		.out    (draws)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("held input word lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && pair.count == 2'd0 |-> !load)
		else $error("empty word loaded");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free && pair.count != 2'd0 |-> !chars.ready)
		else $error("input taken over a blocked word");

endmodule
